@@ rtl/first_fit_coalescing_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit coalescing allocator
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define FFCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define FFCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// ffca_pkg
// Request and result types and fixed codes of the first-fit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffca_pkg;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NO_FIT  = 1'b1;

  localparam int SIZE_W   = 11;
  localparam int OFFSET_W = 10;

  typedef struct packed {
    logic                op;
    logic [SIZE_W-1:0]   request_size;
    logic [OFFSET_W-1:0] free_offset;
  } in_req_t;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] payload_offset;
    logic [SIZE_W-1:0]   granted_size;
  } out_rsp_t;

endpackage

@@ rtl/first_fit_coalescing_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// Address-ordered free list with first-fit allocate and coalescing free.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: raise start with in_req; it is taken on a clock edge
//   where busy is low. busy stays high until the result is issued.
//   Result channel: out_valid is high for one cycle with out_rsp; the
//   receiver cannot stall, so the result must be captured in that cycle.
// Memories and walk:
//   The free list lives in two single-port-read memories (block size and
//   next link) with registered read data. The list walk visits one
//   node per cycle, then an allocate writes and unlinks the granted block and
//   a free links the block in and merges it with touching neighbours.
//   A free below the header or past the arena is answered in the next cycle.
// Reset:
//   Synchronous active-low reset gives one free block at offset 0 covering
//   the arena minus its header; no clearing pass is needed because only
//   entry 0 has a defined reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_fit_coalescing_allocator_macros.svh"

module first_fit_coalescing_allocator
  import ffca_pkg::*;
#(
  parameter int ARENA_BYTES  = 1024,
  parameter int HEADER_BYTES = 16,
  parameter int NODE_BYTES   = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int AW = $clog2(ARENA_BYTES);
  localparam int LW = AW + 1;
  localparam int WW = ((LW > SIZE_W) ? LW : SIZE_W) + 2;

  localparam logic [WW-1:0] ARENA_W  = WW'(ARENA_BYTES);
  localparam logic [WW-1:0] HDR_W    = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] NODE1_W  = WW'(NODE_BYTES + 1);
  localparam logic [LW-1:0] LINK_NUL = LW'(ARENA_BYTES);
  localparam logic [LW-1:0] SZ_RESET = LW'(ARENA_BYTES - HEADER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_A_START, S_A_CHK, S_A_FIX, S_A_LINK,
    S_F_START, S_F_WALK, S_F_LINK, S_F_HEAD, S_F_NEXT, S_F_PREV
  } state_t;

  // storage
  logic [LW-1:0] size_mem [ARENA_BYTES];
  logic [LW-1:0] next_mem [ARENA_BYTES];

  state_t        state_r, state_nxt;
  logic [WW-1:0] req_r, req_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] szn_r, szn_nxt;
  logic [LW-1:0] nlink_r, nlink_nxt;
  logic [LW-1:0] gsz_r, gsz_nxt;
  logic          split_r, split_nxt;
  logic [AW-1:0] nxt_r, nxt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_rsp_r, out_rsp_nxt;
  logic          sz0_vld_r, nx0_vld_r, sz0_hit_r, nx0_hit_r;

  // memory port controls
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] sz_q, nx_q;
  logic          sz_we, nx_we;
  logic [AW-1:0] sz_wa, nx_wa;
  logic [LW-1:0] sz_wd, nx_wd;

  // read data with entry-0 reset values folded in
  logic [LW-1:0] sz_rd, nx_rd, lnk;
  logic [WW-1:0] sz_w, lnk_w, cur_w, prev_w, node_w, head_w, off_w;
  logic [WW-1:0] nxt_sum, split_thr, merge_sum;

  assign sz_rd  = sz0_hit_r ? SZ_RESET : sz_q;
  assign nx_rd  = nx0_hit_r ? LINK_NUL : nx_q;
  assign lnk    = (WW'(nx_rd) < ARENA_W) ? nx_rd : LINK_NUL;
  assign sz_w   = WW'(sz_rd);
  assign lnk_w  = WW'(lnk);
  assign cur_w  = WW'(cur_r);
  assign prev_w = WW'(prev_r);
  assign node_w = WW'(node_r);
  assign head_w = WW'(head_r);
  assign off_w  = WW'(in_req.free_offset);

  // memories: one write and one read address each cycle
  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_wa] <= sz_wd;
    end
    if (rd_en) begin
      sz_q <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (rd_en) begin
      nx_q <= next_mem[rd_addr];
    end
  end

  // next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    node_nxt      = node_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    head_nxt      = head_r;
    szn_nxt       = szn_r;
    nlink_nxt     = nlink_r;
    gsz_nxt       = gsz_r;
    split_nxt     = split_r;
    nxt_nxt       = nxt_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    sz_we         = 1'b0;
    sz_wa         = '0;
    sz_wd         = '0;
    nx_we         = 1'b0;
    nx_wa         = '0;
    nx_wd         = '0;
    nxt_sum       = cur_w + HDR_W + req_r;
    split_thr     = req_r + NODE1_W;
    merge_sum     = node_w + HDR_W + WW'(szn_r);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = WW'(in_req.request_size);
          node_nxt  = AW'(off_w - HDR_W);
          prev_nxt  = LINK_NUL;
          steps_nxt = '0;
          cur_nxt   = (head_w < ARENA_W) ? head_r : LINK_NUL;
          if (in_req.op == OP_ALLOC) begin
            state_nxt = S_A_START;
          end else if (off_w < HDR_W || (off_w - HDR_W) >= ARENA_W) begin
            // ignored free: all-zero result straight away
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end else begin
            state_nxt = S_F_START;
          end
        end
      end

      // allocate: walk first-fit
      S_A_START: begin
        if (cur_w < ARENA_W) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_r);
          state_nxt = S_A_CHK;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{status: ST_NO_FIT, default: '0};
          state_nxt     = S_IDLE;
        end
      end

      S_A_CHK: begin
        if (sz_w < req_r) begin
          steps_nxt = steps_r + 1'b1;
          prev_nxt  = cur_r;
          cur_nxt   = lnk;
          if (WW'(steps_r) + 1 >= ARENA_W || lnk == LINK_NUL) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{status: ST_NO_FIT, default: '0};
            state_nxt     = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(lnk);
          end
        end else begin
          nxt_nxt = AW'(nxt_sum);
          if (sz_w >= split_thr && nxt_sum < ARENA_W) begin
            // carve the tail off as a new free node
            split_nxt = 1'b1;
            gsz_nxt   = LW'(req_r);
            nlink_nxt = LW'(nxt_sum);
            sz_we     = 1'b1;
            sz_wa     = AW'(nxt_sum);
            sz_wd     = LW'(sz_w - (HDR_W + req_r));
            nx_we     = 1'b1;
            nx_wa     = AW'(nxt_sum);
            nx_wd     = lnk;
          end else begin
            split_nxt = 1'b0;
            gsz_nxt   = sz_rd;
            nlink_nxt = lnk;
          end
          state_nxt = S_A_FIX;
        end
      end

      S_A_FIX: begin
        sz_we = 1'b1;
        sz_wa = AW'(cur_r);
        sz_wd = gsz_r;
        if (split_r) begin
          nx_we = 1'b1;
          nx_wa = AW'(cur_r);
          nx_wd = LW'(nxt_r);
        end
        state_nxt = S_A_LINK;
      end

      S_A_LINK: begin
        // unlink the granted block
        if (prev_w < ARENA_W) begin
          nx_we = 1'b1;
          nx_wa = AW'(prev_r);
          nx_wd = nlink_r;
        end else begin
          head_nxt = nlink_r;
        end
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{status: ST_DONE,
                          payload_offset: OFFSET_W'(cur_w + HDR_W),
                          granted_size: SIZE_W'(gsz_r)};
        state_nxt     = S_IDLE;
      end

      // free: find insertion point
      S_F_START: begin
        if (cur_w < ARENA_W && node_w > cur_w) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(cur_r);
          state_nxt = S_F_WALK;
        end else begin
          state_nxt = S_F_LINK;
        end
      end

      S_F_WALK: begin
        steps_nxt = steps_r + 1'b1;
        if (WW'(steps_r) + 1 >= ARENA_W) begin
          cur_nxt   = LINK_NUL;
          state_nxt = S_F_LINK;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = lnk;
          if (lnk_w < ARENA_W && node_w > lnk_w) begin
            rd_en   = 1'b1;
            rd_addr = AW'(lnk);
          end else begin
            state_nxt = S_F_LINK;
          end
        end
      end

      S_F_LINK: begin
        nx_we     = 1'b1;
        nx_wa     = node_r;
        nx_wd     = cur_r;
        rd_en     = 1'b1;
        rd_addr   = node_r;
        state_nxt = S_F_HEAD;
      end

      S_F_HEAD: begin
        if (prev_w < ARENA_W) begin
          nx_we = 1'b1;
          nx_wa = AW'(prev_r);
          nx_wd = LW'(node_r);
        end else begin
          head_nxt = LW'(node_r);
        end
        szn_nxt   = sz_rd;
        nlink_nxt = cur_r;
        if (cur_w < ARENA_W) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cur_r);
        end
        state_nxt = S_F_NEXT;
      end

      S_F_NEXT: begin
        // merge with the following block when they touch
        if (cur_w < ARENA_W && merge_sum == cur_w) begin
          szn_nxt   = LW'(WW'(szn_r) + HDR_W + sz_w);
          nlink_nxt = lnk;
          sz_we     = 1'b1;
          sz_wa     = node_r;
          sz_wd     = LW'(WW'(szn_r) + HDR_W + sz_w);
          nx_we     = 1'b1;
          nx_wa     = node_r;
          nx_wd     = lnk;
        end
        if (prev_w < ARENA_W) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(prev_r);
          state_nxt = S_F_PREV;
        end else begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end

      S_F_PREV: begin
        // merge into the preceding block when they touch
        if (prev_w + HDR_W + sz_w == node_w) begin
          sz_we = 1'b1;
          sz_wa = AW'(prev_r);
          sz_wd = LW'(sz_w + HDR_W + WW'(szn_r));
          nx_we = 1'b1;
          nx_wa = AW'(prev_r);
          nx_wd = nlink_r;
        end
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '0;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      sz0_vld_r   <= 1'b0;
      nx0_vld_r   <= 1'b0;
      sz0_hit_r   <= 1'b0;
      nx0_hit_r   <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
      if (sz_we && sz_wa == '0) begin
        sz0_vld_r <= 1'b1;
      end
      if (nx_we && nx_wa == '0) begin
        nx0_vld_r <= 1'b1;
      end
      if (rd_en) begin
        sz0_hit_r <= (rd_addr == '0) && !sz0_vld_r;
        nx0_hit_r <= (rd_addr == '0) && !nx0_vld_r;
      end
    end
    req_r     <= req_nxt;
    node_r    <= node_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    szn_r     <= szn_nxt;
    nlink_r   <= nlink_nxt;
    gsz_r     <= gsz_nxt;
    split_r   <= split_nxt;
    nxt_r     <= nxt_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // checks
  `FFCA_ASSERT_NOW(a_rsp_idle, out_valid_r, state_r == S_IDLE, "result outside idle")
  `FFCA_ASSERT_NEXT(a_req_progress, start && !busy, busy || out_valid_r,
                    "request neither started nor answered")
  `FFCA_ASSERT_NOW(a_fail_zero, out_valid_r && out_rsp_r.status == ST_NO_FIT,
                   out_rsp_r.payload_offset == '0 && out_rsp_r.granted_size == '0,
                   "failed allocate carries data")
  `FFCA_ASSERT_NOW(a_walk_bound, busy, WW'(steps_r) < ARENA_W, "walk exceeded limit")

endmodule
